FILE: design/assert_macros.svh
// Assertion helpers included by the top-level reporter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge while out of reset.
`define DBSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dbsc: implication check failed");

// Next-cycle implication checked on every rising edge while out of reset.
`define DBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dbsc: next-cycle check failed");

`endif

FILE: design/dbsc_pkg.sv
`timescale 1ns / 1ps

package dbsc_pkg;

    // Configuration port geometry: five 32-bit registers at 4-byte spacing.
    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_POS_DB = 3'd0,
        REG_ANG_DB = 3'd1,
        REG_VEL_EN = 3'd2,
        REG_HB     = 3'd3,
        REG_GAP    = 3'd4
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [15:0] PosDbReset   = 16'd5;
    localparam logic [31:0] PosDbSqReset = 32'd25;
    localparam logic [15:0] AngDbReset   = 16'd64;
    localparam logic        VelEnReset   = 1'b1;
    localparam logic [15:0] HbReset      = 16'd20;
    localparam logic [15:0] GapReset     = 16'd2;

    localparam logic [15:0] QuietMax = 16'hFFFF;

    // One observed sample.
    typedef struct packed {
        logic [31:0] entity_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [47:0] angles;
        logic [47:0] velocity;
        logic [15:0] stance_anim;
        logic [31:0] equipment_id;
    } sample_t;

    // Last emitted sample, used as the comparison reference.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [47:0] angles;
        logic [15:0] stance_anim;
        logic [31:0] equipment_id;
    } ref_t;

    // Current configuration, with the squared position deadband kept alongside.
    typedef struct packed {
        logic [15:0] pos_db;
        logic [31:0] pos_db_sq;
        logic [15:0] ang_db;
        logic        vel_en;
        logic [15:0] hb;
        logic [15:0] gap;
    } cfg_t;

endpackage

FILE: design/dbsc_cfg_regs.sv
`timescale 1ns / 1ps

module dbsc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbsc_pkg::AddrWidth-1:0]  paddr,
    input  logic [dbsc_pkg::DataWidth-1:0]  pwdata,
    output logic [dbsc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    output dbsc_pkg::cfg_t                  cfg
);
    import dbsc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register write decode; the square of the position deadband is formed here once.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_POS_DB: begin
                    cfg_next.pos_db    = pwdata[15:0];
                    cfg_next.pos_db_sq = 32'(pwdata[15:0]) * 32'(pwdata[15:0]);
                end
                REG_ANG_DB: cfg_next.ang_db = pwdata[15:0];
                REG_VEL_EN: cfg_next.vel_en = pwdata[0];
                REG_HB:     cfg_next.hb     = pwdata[15:0];
                REG_GAP:    cfg_next.gap    = pwdata[15:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_db    <= PosDbReset;
            cfg_reg.pos_db_sq <= PosDbSqReset;
            cfg_reg.ang_db    <= AngDbReset;
            cfg_reg.vel_en    <= VelEnReset;
            cfg_reg.hb        <= HbReset;
            cfg_reg.gap       <= GapReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb begin
        case (idx)
            REG_POS_DB: prdata = 32'(cfg_reg.pos_db);
            REG_ANG_DB: prdata = 32'(cfg_reg.ang_db);
            REG_VEL_EN: prdata = 32'(cfg_reg.vel_en);
            REG_HB:     prdata = 32'(cfg_reg.hb);
            REG_GAP:    prdata = 32'(cfg_reg.gap);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: design/dbsc_change_detect.sv
`timescale 1ns / 1ps

module dbsc_change_detect (
    input  dbsc_pkg::sample_t smp,
    input  dbsc_pkg::ref_t    ref_st,
    input  dbsc_pkg::cfg_t    cfg,
    output logic              changed
);
    import dbsc_pkg::*;

    logic        [2:0][31:0] cur_pos;
    logic        [2:0][31:0] old_pos;
    logic signed [2:0][32:0] dpos;
    logic        [2:0][32:0] apos;
    logic        [2:0][31:0] sq;
    logic        [2:0]       axis_over;
    logic        [33:0]      sq_sum;
    logic                    pos_moved;
    logic signed [2:0][16:0] dang;
    logic        [2:0][16:0] aang;
    logic        [2:0]       ang_over;

    assign cur_pos = {smp.pos_z, smp.pos_y, smp.pos_x};
    assign old_pos = {ref_st.pos_z, ref_st.pos_y, ref_st.pos_x};

    // Per-axis absolute difference. Once every axis is within the deadband,
    // each difference fits 16 bits, so the squares are 16 by 16.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dpos[i] = $signed({cur_pos[i][31], cur_pos[i]})
                    - $signed({old_pos[i][31], old_pos[i]});
            apos[i] = dpos[i][32] ? 33'(-dpos[i]) : 33'(dpos[i]);
            axis_over[i] = apos[i] > {17'd0, cfg.pos_db};
            sq[i] = 32'(apos[i][15:0]) * 32'(apos[i][15:0]);
        end
    end

    assign sq_sum    = 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
    assign pos_moved = (|axis_over) || (sq_sum > {2'd0, cfg.pos_db_sq});

    // Plain signed lane differences, no wrap at half a turn.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dang[i] = $signed({smp.angles[16*i+15], smp.angles[16*i +: 16]})
                    - $signed({ref_st.angles[16*i+15], ref_st.angles[16*i +: 16]});
            aang[i] = dang[i][16] ? 17'(-dang[i]) : 17'(dang[i]);
            ang_over[i] = aang[i] > {1'b0, cfg.ang_db};
        end
    end

    assign changed = pos_moved || (|ang_over)
                  || (smp.stance_anim != ref_st.stance_anim)
                  || (smp.equipment_id != ref_st.equipment_id);

endmodule

FILE: design/deadband_state_change_reporter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Deadband state-change reporter: takes one entity state sample per transfer and
// emits it only when it differs from the last emitted sample by more than the
// configured deadbands, or when the heartbeat forces a resend; the first sample
// after reset is always emitted, and a changed sample arriving within the minimum
// gap after the last emit is dropped. A sample is registered on input, decided
// combinationally against the stored reference, and, if it emits, moves from the
// input register into the output register; a full output register holds it back
// in the input register. One sample is accepted every cycle; the only thing that
// stops the input is a result waiting in the output register while the sample
// behind it would also emit.
module deadband_state_change_reporter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbsc_pkg::AddrWidth-1:0]  paddr,
    input  logic [dbsc_pkg::DataWidth-1:0]  pwdata,
    output logic [dbsc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    // Sample input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic        [31:0]              s_entity_id,
    input  logic signed [31:0]              s_pos_x,
    input  logic signed [31:0]              s_pos_y,
    input  logic signed [31:0]              s_pos_z,
    input  logic        [47:0]              s_angles_packed,
    input  logic        [47:0]              s_velocity_packed,
    input  logic        [15:0]              s_stance_anim,
    input  logic        [31:0]              s_equipment_id,
    // Emitted result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic        [31:0]              m_out_entity_id,
    output logic signed [31:0]              m_out_pos_x,
    output logic signed [31:0]              m_out_pos_y,
    output logic signed [31:0]              m_out_pos_z,
    output logic        [47:0]              m_out_angles_packed,
    output logic        [47:0]              m_out_velocity_packed,
    output logic        [15:0]              m_out_stance_anim,
    output logic        [31:0]              m_out_equipment_id,
    output logic        [31:0]              m_emit_sequence,
    output logic        [31:0]              m_emit_tick
);
    import dbsc_pkg::*;

    cfg_t        cfg;
    sample_t     in_smp_reg;
    logic        in_valid_reg;
    ref_t        ref_reg;
    logic        have_ref_reg;
    logic [15:0] quiet_reg;
    logic [15:0] quiet_next;
    logic [31:0] seq_reg;
    logic [31:0] tick_reg;
    logic [31:0] last_emit_reg;
    sample_t     out_smp_reg;
    logic [31:0] out_seq_reg;
    logic [31:0] out_tick_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        changed;
    logic [31:0] tick_new;
    logic [31:0] gap_dist;
    logic        gap_hold;
    logic [15:0] quiet_inc;
    logic        hb_fire;
    logic        emit;
    logic        out_free;
    logic        in_adv;

    dbsc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbsc_change_detect u_detect (
        .smp     (in_smp_reg),
        .ref_st  (ref_reg),
        .cfg     (cfg),
        .changed (changed)
    );

    // Emit decision for the sample in the input register.
    assign tick_new  = tick_reg + 32'd1;
    assign gap_dist  = tick_new - last_emit_reg;
    assign gap_hold  = (cfg.gap != 16'd0) && (last_emit_reg != 32'd0)
                    && (gap_dist < {16'd0, cfg.gap});
    assign quiet_inc = (quiet_reg != QuietMax) ? quiet_reg + 16'd1 : quiet_reg;
    assign hb_fire   = (cfg.hb != 16'd0) && (quiet_inc >= cfg.hb);
    assign emit      = !have_ref_reg || (changed ? !gap_hold : hb_fire);

    // The input stage moves on unless its sample emits into a full output register.
    assign out_free = !out_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && (!emit || out_free);
    assign s_ready  = !in_valid_reg || in_adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_smp_reg.entity_id    <= s_entity_id;
            in_smp_reg.pos_x        <= s_pos_x;
            in_smp_reg.pos_y        <= s_pos_y;
            in_smp_reg.pos_z        <= s_pos_z;
            in_smp_reg.angles       <= s_angles_packed;
            in_smp_reg.velocity     <= s_velocity_packed;
            in_smp_reg.stance_anim  <= s_stance_anim;
            in_smp_reg.equipment_id <= s_equipment_id;
        end
    end

    // Quiet counter: cleared on emit, counts unchanged samples while the heartbeat is on.
    always_comb begin
        quiet_next = quiet_reg;
        if (emit) begin
            quiet_next = 16'd0;
        end else if (!changed && (cfg.hb != 16'd0)) begin
            quiet_next = quiet_inc;
        end
    end

    // Filter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_ref_reg  <= 1'b0;
            quiet_reg     <= 16'd0;
            seq_reg       <= 32'd0;
            tick_reg      <= 32'd0;
            last_emit_reg <= 32'd0;
        end else if (in_adv) begin
            tick_reg  <= tick_new;
            quiet_reg <= quiet_next;
            if (emit) begin
                have_ref_reg  <= 1'b1;
                seq_reg       <= seq_reg + 32'd1;
                last_emit_reg <= tick_new;
            end
        end
    end

    // Reference sample, only read once a first emit has set it.
    always_ff @(posedge aclk) begin
        if (in_adv && emit) begin
            ref_reg.pos_x        <= in_smp_reg.pos_x;
            ref_reg.pos_y        <= in_smp_reg.pos_y;
            ref_reg.pos_z        <= in_smp_reg.pos_z;
            ref_reg.angles       <= in_smp_reg.angles;
            ref_reg.stance_anim  <= in_smp_reg.stance_anim;
            ref_reg.equipment_id <= in_smp_reg.equipment_id;
        end
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_adv && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && emit) begin
            out_smp_reg.entity_id    <= in_smp_reg.entity_id;
            out_smp_reg.pos_x        <= in_smp_reg.pos_x;
            out_smp_reg.pos_y        <= in_smp_reg.pos_y;
            out_smp_reg.pos_z        <= in_smp_reg.pos_z;
            out_smp_reg.angles       <= in_smp_reg.angles;
            out_smp_reg.velocity     <= cfg.vel_en ? in_smp_reg.velocity : 48'd0;
            out_smp_reg.stance_anim  <= in_smp_reg.stance_anim;
            out_smp_reg.equipment_id <= in_smp_reg.equipment_id;
            out_seq_reg              <= seq_reg + 32'd1;
            out_tick_reg             <= tick_new;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_out_entity_id       = out_smp_reg.entity_id;
    assign m_out_pos_x           = out_smp_reg.pos_x;
    assign m_out_pos_y           = out_smp_reg.pos_y;
    assign m_out_pos_z           = out_smp_reg.pos_z;
    assign m_out_angles_packed   = out_smp_reg.angles;
    assign m_out_velocity_packed = out_smp_reg.velocity;
    assign m_out_stance_anim     = out_smp_reg.stance_anim;
    assign m_out_equipment_id    = out_smp_reg.equipment_id;
    assign m_emit_sequence       = out_seq_reg;
    assign m_emit_tick           = out_tick_reg;

    // Checks on the filter state and the result register.
    `DBSC_ASSERT_NEXT(a_emit_sets_ref, aclk, aresetn, in_adv && emit, have_ref_reg)
    `DBSC_ASSERT_NEXT(a_seq_step, aclk, aresetn, in_adv && emit,
                      seq_reg == $past(seq_reg) + 32'd1)
    `DBSC_ASSERT_NEXT(a_quiet_clear, aclk, aresetn, in_adv && emit, quiet_reg == 16'd0)
    `DBSC_ASSERT_NEXT(a_tick_hold, aclk, aresetn, !in_adv, tick_reg == $past(tick_reg))
    `DBSC_ASSERT_NEXT(a_result_seq, aclk, aresetn, in_adv && emit,
                      m_valid && (m_emit_sequence == seq_reg) && (m_emit_tick == tick_reg))

endmodule
